/* rtl/hwc_pkg.sv */
// Hamming word codec: shared package.
// Holds field widths, codes, the result struct and elaboration-time helpers.
// No dependencies.
package hwc_pkg;

	localparam int WORD_W                = 16;
	localparam int SYN_W                 = 4;
	localparam int DATA_BITS_W           = 4;
	localparam int DEFAULT_MAX_DATA_BITS = 11;
	localparam int APB_ADDR_W            = 3;
	localparam int APB_DATA_W            = 32;

	localparam logic [DATA_BITS_W-1:0] DATA_BITS_RESET = 4'd4;

	// Register index taken from paddr above the byte offset
	localparam logic [APB_ADDR_W-3:0] REG_DATA_BITS = '0;

	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word_out;
		logic [SYN_W-1:0]  syndrome;
		logic              corrected;
		logic              uncorrectable;
	} hwc_result_t;

	// Least r with 2^r >= d + r + 1
	function automatic int parity_count(input int d);
		int r;
		r = 0;
		while ((1 << r) < (d + r + 1))
			r++;
		return r;
	endfunction

	function automatic bit is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// Data bit index (0 = first data bit) held at a non-power-of-two position
	function automatic int data_index(input int p);
		return p - $clog2(p + 1) - 1;
	endfunction

endpackage

/* rtl/hwc_channels.sv */
// Hamming word codec: valid/ready channel interfaces for items in and results out.
// Depends on hwc_pkg for field widths.
interface hwc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [hwc_pkg::WORD_W-1:0]  word_in;

	modport source (output valid, output action, output word_in, input ready);
	modport sink   (input valid, input action, input word_in, output ready);
endinterface

interface hwc_out_if;
	logic                        valid;
	logic                        ready;
	logic [hwc_pkg::WORD_W-1:0]  word_out;
	logic [hwc_pkg::SYN_W-1:0]   syndrome;
	logic                        corrected;
	logic                        uncorrectable;

	modport source (output valid, output word_out, output syndrome, output corrected,
		output uncorrectable, input ready);
	modport sink   (input valid, input word_out, input syndrome, input corrected,
		input uncorrectable, output ready);
endinterface

/* rtl/hwc_core.sv */
// Hamming word codec: combinational encode/decode of one word.
// Depends on hwc_pkg (widths, codes, result struct, position helpers).
module hwc_core #(
	parameter int MAX_DATA_BITS = hwc_pkg::DEFAULT_MAX_DATA_BITS
) (
	input  logic [hwc_pkg::DATA_BITS_W-1:0] data_bits,
	input  logic                            action,
	input  logic [hwc_pkg::WORD_W-1:0]      word_in,
	output hwc_pkg::hwc_result_t            result
);

	localparam int MAXD = MAX_DATA_BITS;
	localparam int RMAX = hwc_pkg::parity_count(MAXD);
	localparam int NMAX = MAXD + RMAX;
	localparam int DW   = $clog2(MAXD + 1);
	localparam int PW   = $clog2(NMAX + 1);
	localparam int RW   = $clog2(RMAX + 1);
	localparam int EW   = DW + hwc_pkg::DATA_BITS_W;
	localparam int CW   = RMAX + PW;

	logic [EW-1:0]   d_raw;
	logic [DW-1:0]   d_eff;
	logic [RW-1:0]   r_eff;
	logic [PW-1:0]   n_eff;
	logic [DW-1:0]   d_pad;
	logic [PW-1:0]   n_pad;

	logic [MAXD-1:0] data_l;
	logic [NMAX:1]   enc_pos;
	logic [RMAX-1:0] enc_par;
	logic [NMAX-1:0] enc_l;
	logic [NMAX-1:0] enc_word;

	logic [NMAX-1:0] dec_l;
	logic [NMAX:1]   dec_pos;
	logic [RMAX-1:0] syn;
	logic            corr;
	logic            unc;
	logic [MAXD-1:0] dat_l;
	logic [MAXD-1:0] dat_word;

	// Effective width: zero reads as one, above the maximum clamps
	always_comb begin
		d_raw = EW'(data_bits);
		if (d_raw == '0) begin
			d_eff = DW'(1);
		end else if (d_raw > EW'(MAXD)) begin
			d_eff = DW'(MAXD);
		end else begin
			d_eff = DW'(d_raw);
		end
		r_eff = '0;
		for (int i = 0; i < RMAX; i++) begin
			if ((PW + 1)'(1 << i) < (PW + 1)'(int'(d_eff) + i + 1))
				r_eff = r_eff + RW'(1);
		end
		n_eff = PW'(d_eff) + PW'(r_eff);
		d_pad = DW'(MAXD) - d_eff;
		n_pad = PW'(NMAX) - n_eff;
	end

	// Encode: left-align data, place it by position, fill parity
	always_comb begin
		data_l = MAXD'(word_in) << d_pad;
		enc_pos = '0;
		for (int p = 1; p <= NMAX; p++) begin
			if (!hwc_pkg::is_pow2(p))
				enc_pos[p] = data_l[MAXD - 1 - hwc_pkg::data_index(p)];
		end
		for (int i = 0; i < RMAX; i++) begin
			enc_par[i] = 1'b0;
			for (int p = 1; p <= NMAX; p++) begin
				if (((p >> i) & 1) == 1)
					enc_par[i] = enc_par[i] ^ enc_pos[p];
			end
		end
		enc_l = '0;
		for (int p = 1; p <= NMAX; p++) begin
			if (hwc_pkg::is_pow2(p))
				enc_l[NMAX - p] = enc_par[$clog2(p)];
			else
				enc_l[NMAX - p] = enc_pos[p];
		end
		enc_word = enc_l >> n_pad;
	end

	// Decode: left-align codeword (surplus bits drop off the top), check, fix, extract
	always_comb begin
		dec_l = NMAX'(word_in) << n_pad;
		for (int i = 0; i < RMAX; i++) begin
			syn[i] = 1'b0;
			for (int p = 1; p <= NMAX; p++) begin
				if (((p >> i) & 1) == 1)
					syn[i] = syn[i] ^ dec_l[NMAX - p];
			end
		end
		corr = (syn != '0) && (CW'(syn) <= CW'(n_eff));
		unc  = CW'(syn) > CW'(n_eff);
		for (int p = 1; p <= NMAX; p++) begin
			dec_pos[p] = dec_l[NMAX - p] ^ (corr && (CW'(syn) == CW'(p)));
		end
		dat_l = '0;
		for (int p = 1; p <= NMAX; p++) begin
			if (!hwc_pkg::is_pow2(p))
				dat_l[MAXD - 1 - hwc_pkg::data_index(p)] = dec_pos[p];
		end
		dat_word = dat_l >> d_pad;
	end

	always_comb begin
		if (action == hwc_pkg::ACT_DECODE) begin
			result.word_out      = hwc_pkg::WORD_W'(dat_word);
			result.syndrome      = hwc_pkg::SYN_W'(syn);
			result.corrected     = corr;
			result.uncorrectable = unc;
		end else begin
			result.word_out      = hwc_pkg::WORD_W'(enc_word);
			result.syndrome      = '0;
			result.corrected     = 1'b0;
			result.uncorrectable = 1'b0;
		end
	end

endmodule

/* rtl/hamming_word_codec.sv */
// Hamming word codec top level: APB register, input register, result register.
// Depends on hwc_pkg, hwc_in_if / hwc_out_if (hwc_channels.sv) and hwc_core.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------------
//  din     | in  | valid / ready    | action, word_in
//  dout    | out | valid / ready    | word_out, syndrome, corrected, uncorrectable
//  apb     | in  | psel / penable   | paddr, pwdata (write), prdata (read)
//
// An item sits first in the input register; the combinational codec logic
// between the input and result registers lands it in the result register, which
// drives dout. One item is accepted every clock while dout takes results.
// A stalled dout holds the result register; the input register still takes one more
// item, after which din.ready drops until dout drains.
// arst_n clears both valid flags and sets data_bits to 4; no clearing pass is needed.
module hamming_word_codec #(
	parameter int MAX_DATA_BITS = hwc_pkg::DEFAULT_MAX_DATA_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hwc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hwc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [hwc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	hwc_in_if.sink                         din,
	hwc_out_if.source                      dout
);

	logic [hwc_pkg::DATA_BITS_W-1:0] data_bits_q;
	logic                            reg_hit;

	logic                            valid_s1;
	logic                            action_s1;
	logic [hwc_pkg::WORD_W-1:0]      word_s1;
	logic                            valid_s2;
	hwc_pkg::hwc_result_t            result_s2;
	hwc_pkg::hwc_result_t            result_comb;
	logic                            adv_s2;
	logic                            adv_s1;

	// Configuration port: zero-wait, register index sits above the byte offset
	assign pready  = 1'b1;
	assign reg_hit = (paddr[hwc_pkg::APB_ADDR_W-1:2] == hwc_pkg::REG_DATA_BITS);
	assign prdata  = reg_hit ? hwc_pkg::APB_DATA_W'(data_bits_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= hwc_pkg::DATA_BITS_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			data_bits_q <= pwdata[hwc_pkg::DATA_BITS_W-1:0];
		end
	end

	// Result register advances when empty or when dout takes its item;
	// input register advances when empty or when it hands its item on.
	assign adv_s2    = !valid_s2 || dout.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign din.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= din.valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Payload registers: load on advance, hold otherwise
	always_ff @(posedge clk) begin
		if (adv_s1 && din.valid) begin
			action_s1 <= din.action;
			word_s1   <= din.word_in;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_comb;
		end
	end

	hwc_core #(
		.MAX_DATA_BITS (MAX_DATA_BITS)
	) u_core (
		.data_bits (data_bits_q),
		.action    (action_s1),
		.word_in   (word_s1),
		.result    (result_comb)
	);

	assign dout.valid         = valid_s2;
	assign dout.word_out      = result_s2.word_out;
	assign dout.syndrome      = result_s2.syndrome;
	assign dout.corrected     = result_s2.corrected;
	assign dout.uncorrectable = result_s2.uncorrectable;

endmodule

/* rtl/hwc_checker.sv */
// Hamming word codec: port-level checker and its bind to the top level.
// Depends on hwc_pkg for field widths; sees only the top level's ports.
module hwc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [hwc_pkg::WORD_W-1:0]  word_out,
	input logic [hwc_pkg::SYN_W-1:0]   syndrome,
	input logic                        corrected,
	input logic                        uncorrectable
);

	logic [2:0] inflight_q;

	// Count items taken in and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({word_out, syndrome, corrected, uncorrectable}))
		else $error("stalled result changed or dropped");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("more than two items held inside");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result shown with no item accepted");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(corrected && uncorrectable))
		else $error("corrected and uncorrectable both set");

endmodule

bind hamming_word_codec hwc_checker u_hwc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (din.valid),
	.in_ready      (din.ready),
	.out_valid     (dout.valid),
	.out_ready     (dout.ready),
	.word_out      (dout.word_out),
	.syndrome      (dout.syndrome),
	.corrected     (dout.corrected),
	.uncorrectable (dout.uncorrectable)
);
